// ----- rtl/core/ifrdp_pkg.sv -----
// Package for the info frame receiver: codes, limits, config and result types.
// No dependencies; imported by every module of the receiver.
`timescale 1ns / 1ps
`default_nettype none

package ifrdp_pkg;

    // Frame size limit and counter width
    localparam int MAX_PAYLOAD = 2048;
    localparam int CNT_W       = 12;
    localparam int CFG_IDX_W   = 3;

    // Parser state codes
    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_FLAG = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_CTRL = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLAG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd5;

    // Config reset values
    localparam logic [7:0] RST_FLAG   = 8'd126;
    localparam logic [7:0] RST_ADDR   = 8'd3;
    localparam logic [7:0] RST_CTRL0  = 8'd0;
    localparam logic [7:0] RST_CTRL1  = 8'd64;
    localparam logic [7:0] RST_ESCAPE = 8'd125;
    localparam logic [7:0] RST_MASK   = 8'd32;

    // Result codes
    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_REPORT  = 1'b1;
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_PARITY   = 2'd1;
    localparam logic [1:0] ERR_LONG     = 2'd2;
    localparam logic [1:0] ERR_MALFORM  = 2'd3;
    localparam logic       ACK_RR       = 1'b0;
    localparam logic       ACK_REJ      = 1'b1;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] address_byte;
        logic [7:0] ctrl_seq_zero;
        logic [7:0] ctrl_seq_one;
        logic [7:0] escape_byte;
        logic [7:0] unstuff_mask;
    } t_cfg;

    typedef struct packed {
        logic             out_kind;
        logic [7:0]       payload_byte;
        logic [CNT_W-1:0] payload_len;
        logic [1:0]       error_code;
        logic             ack_kind;
        logic             ack_seq;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/ifrdp_cfg_regs.sv -----
// Configuration register bank of the info frame receiver.
// Depends on ifrdp_pkg for register indexes, reset values and t_cfg.
`timescale 1ns / 1ps
`default_nettype none

module ifrdp_cfg_regs
    import ifrdp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte     <= RST_FLAG;
            r_cfg.address_byte  <= RST_ADDR;
            r_cfg.ctrl_seq_zero <= RST_CTRL0;
            r_cfg.ctrl_seq_one  <= RST_CTRL1;
            r_cfg.escape_byte   <= RST_ESCAPE;
            r_cfg.unstuff_mask  <= RST_MASK;
        end else if (i_cfg_wr_en) begin
            // indexes past the last register are dropped
            case (i_cfg_index)
                REG_FLAG:   r_cfg.flag_byte     <= i_cfg_wdata;
                REG_ADDR:   r_cfg.address_byte  <= i_cfg_wdata;
                REG_CTRL0:  r_cfg.ctrl_seq_zero <= i_cfg_wdata;
                REG_CTRL1:  r_cfg.ctrl_seq_one  <= i_cfg_wdata;
                REG_ESCAPE: r_cfg.escape_byte   <= i_cfg_wdata;
                REG_MASK:   r_cfg.unstuff_mask  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/ifrdp_parser.sv -----
// Frame parser: header hunt, unstuffing, one-byte holdback, parity and report.
// Depends on ifrdp_pkg for state codes, result codes and t_cfg / t_result.
`timescale 1ns / 1ps
`default_nettype none

module ifrdp_parser
    import ifrdp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [CNT_W-1:0] MAX_LEN  = CNT_W'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] OVF_MARK = CNT_W'(MAX_PAYLOAD + 1);

    logic [2:0]       r_state,  n_state;
    logic             r_seq,    n_seq;
    logic             r_esc,    n_esc;
    logic [7:0]       r_held,   n_held;
    logic             r_held_v, n_held_v;
    logic [7:0]       r_parity, n_parity;
    logic [CNT_W-1:0] r_count,  n_count;

    logic [7:0] exp_ctrl;
    logic [7:0] data;
    logic       have_data;

    assign exp_ctrl = r_seq ? i_cfg.ctrl_seq_one : i_cfg.ctrl_seq_zero;

    always_comb begin
        n_state     = r_state;
        n_seq       = r_seq;
        n_esc       = r_esc;
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_parity    = r_parity;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '0;
        data        = i_byte;
        have_data   = 1'b0;

        unique case (r_state)
            ST_FLAG: begin
                if (i_byte == i_cfg.flag_byte)         n_state = ST_FLAG;
                else if (i_byte == i_cfg.address_byte) n_state = ST_ADDR;
                else                                   n_state = ST_HUNT;
            end
            ST_ADDR: begin
                if (i_byte == i_cfg.flag_byte) n_state = ST_FLAG;
                else if (i_byte == exp_ctrl)   n_state = ST_CTRL;
                else                           n_state = ST_HUNT;
            end
            ST_CTRL: begin
                if (i_byte == i_cfg.flag_byte) begin
                    n_state = ST_FLAG;
                end else if (i_byte == (i_cfg.address_byte ^ exp_ctrl)) begin
                    n_state  = ST_DATA;
                    n_esc    = 1'b0;
                    n_held   = '0;
                    n_held_v = 1'b0;
                    n_parity = '0;
                    n_count  = '0;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_DATA: begin
                if (i_byte == i_cfg.flag_byte) begin
                    // closing flag: end of frame report
                    o_res_valid       = 1'b1;
                    o_res.out_kind    = KIND_REPORT;
                    o_res.payload_len = (r_count > MAX_LEN) ? MAX_LEN : r_count;
                    priority if (r_esc || !r_held_v) o_res.error_code = ERR_MALFORM;
                    else if (r_count > MAX_LEN)      o_res.error_code = ERR_LONG;
                    else if (r_parity != r_held)     o_res.error_code = ERR_PARITY;
                    else                             o_res.error_code = ERR_OK;
                    if (o_res.error_code == ERR_OK) begin
                        n_seq          = ~r_seq;
                        o_res.ack_kind = ACK_RR;
                    end else begin
                        o_res.ack_kind = ACK_REJ;
                    end
                    o_res.ack_seq = n_seq;
                    n_state  = ST_HUNT;
                    n_esc    = 1'b0;
                    n_held   = '0;
                    n_held_v = 1'b0;
                    n_parity = '0;
                    n_count  = '0;
                end else if (r_esc) begin
                    n_esc     = 1'b0;
                    data      = i_byte ^ i_cfg.unstuff_mask;
                    have_data = 1'b1;
                end else if (i_byte == i_cfg.escape_byte) begin
                    n_esc = 1'b1;
                end else begin
                    have_data = 1'b1;
                end

                if (have_data) begin
                    n_held   = data;
                    n_held_v = 1'b1;
                    if (r_held_v) begin
                        // release the byte held back one place
                        if (r_count >= MAX_LEN) begin
                            n_count = OVF_MARK;
                        end else begin
                            n_count            = r_count + 1'b1;
                            n_parity           = r_parity ^ r_held;
                            o_res_valid        = 1'b1;
                            o_res.out_kind     = KIND_PAYLOAD;
                            o_res.payload_byte = r_held;
                        end
                    end
                end
            end
            default: begin
                n_state = (i_byte == i_cfg.flag_byte) ? ST_FLAG : ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_seq    <= 1'b0;
            r_esc    <= 1'b0;
            r_held_v <= 1'b0;
            r_parity <= '0;
            r_count  <= '0;
        end else if (i_advance) begin
            r_state  <= n_state;
            r_seq    <= n_seq;
            r_esc    <= n_esc;
            r_held_v <= n_held_v;
            r_parity <= n_parity;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_held <= n_held;
        end
    end

`ifndef SYNTHESIS
    a_esc_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_state == ST_DATA))
        else $error("escape pending outside data phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OVF_MARK)
        else $error("byte count beyond overflow mark");

    a_data_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_state != ST_DATA && n_state == ST_DATA)
        |-> (r_state == ST_CTRL))
        else $error("data phase entered without full header");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_res.out_kind == KIND_REPORT)
        |=> (r_state == ST_HUNT && !r_held_v && r_count == '0))
        else $error("frame state not cleared after report");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/info_frame_receiver_destuff_parity.sv -----
// Path: input register, then parser, then result register, which drives o_out_valid.
// Throughput: one line byte per cycle while o_out_valid is not held by a low i_out_ready;
// the parser state updates as a byte moves between the input and result registers.
// Reset: synchronous, active low; config returns to its defaults, parser hunts
// for an opening flag with sequence bit 0, both pipeline registers empty.
// Depends on ifrdp_pkg, ifrdp_cfg_regs and ifrdp_parser.
`timescale 1ns / 1ps
`default_nettype none

module info_frame_receiver_destuff_parity
    import ifrdp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_out_kind,
    output logic [7:0]                o_payload_byte,
    output logic [CNT_W-1:0]          o_payload_len,
    output logic [1:0]                o_error_code,
    output logic                      o_ack_kind,
    output logic                      o_ack_seq
);

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    advance;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    // a beat moves from the input register into the parser when the result slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    ifrdp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ifrdp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out.out_kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_payload_len  = r_out.payload_len;
    assign o_error_code   = r_out.error_code;
    assign o_ack_kind     = r_out.ack_kind;
    assign o_ack_seq      = r_out.ack_seq;

endmodule

`default_nettype wire

// ----- tb/info_frame_receiver_destuff_parity_tb.sv -----
// Self-checking testbench for the info frame receiver: byte-stuffed frames, parity and acks.
// Drives line bytes against a cycle-free model of the parser and checks every result beat.
// Depends on ifrdp_pkg and info_frame_receiver_destuff_parity.
`timescale 1ns / 1ps

module info_frame_receiver_destuff_parity_tb;
    import ifrdp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_BYTES = 235;
    localparam int HOLD_CYCLES = 200;

    typedef enum int {
        F_GOOD, F_BAD_PARITY, F_DANGLE, F_EMPTY, F_STALE_SEQ, F_BAD_CHECK, F_TRUNC
    } t_flavor;

    typedef struct packed {
        logic [7:0] line;
        logic       typed_on;
        t_result    typed;
    } t_step;

    localparam t_result EMPTY_REJ = '{KIND_REPORT, 8'h00, 12'd0, ERR_MALFORM, ACK_REJ, 1'b0};
    localparam t_result EMPTY_OK  = '{KIND_REPORT, 8'h00, 12'd0, ERR_OK, ACK_RR, 1'b1};
    localparam t_result PAY_FF    = '{KIND_PAYLOAD, 8'hFF, 12'd0, ERR_OK, ACK_RR, 1'b0};
    localparam t_result PAY_FLAG  = '{KIND_PAYLOAD, RST_FLAG, 12'd0, ERR_OK, ACK_RR, 1'b0};
    localparam t_result DANGLE_REJ = '{KIND_REPORT, 8'h00, 12'd2, ERR_MALFORM, ACK_REJ, 1'b1};

    // Directed frames at reset settings
    localparam t_step DIRECTED [25] = '{
        '{RST_FLAG, 1'b0, '0},
        '{RST_FLAG, 1'b0, '0},                      // repeated flag
        '{RST_ADDR, 1'b0, '0},
        '{RST_FLAG, 1'b0, '0},                      // flag inside the header restarts it
        '{RST_ADDR, 1'b0, '0},
        '{RST_CTRL0, 1'b0, '0},
        '{RST_ADDR ^ RST_CTRL0, 1'b0, '0},
        '{RST_FLAG, 1'b1, EMPTY_REJ},               // nothing between check and flag
        '{8'h00, 1'b0, '0},                         // noise while hunting
        '{RST_FLAG, 1'b0, '0},
        '{RST_ADDR, 1'b0, '0},
        '{RST_CTRL0, 1'b0, '0},
        '{RST_ADDR ^ RST_CTRL0, 1'b0, '0},
        '{8'h00, 1'b0, '0},                         // parity only, zero payload
        '{RST_FLAG, 1'b1, EMPTY_OK},
        '{RST_FLAG, 1'b0, '0},
        '{RST_ADDR, 1'b0, '0},
        '{RST_CTRL1, 1'b0, '0},
        '{RST_ADDR ^ RST_CTRL1, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{RST_ESCAPE, 1'b0, '0},
        '{RST_FLAG ^ RST_MASK, 1'b1, PAY_FF},       // stuffed flag value
        '{8'h00, 1'b1, PAY_FLAG},
        '{RST_ESCAPE, 1'b0, '0},
        '{RST_FLAG, 1'b1, DANGLE_REJ}               // open escape outranks bad parity
    };

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b1;
    logic                 o_out_kind;
    logic [7:0]           o_payload_byte;
    logic [CNT_W-1:0]     o_payload_len;
    logic [1:0]           o_error_code;
    logic                 o_ack_kind;
    logic                 o_ack_seq;

    info_frame_receiver_destuff_parity u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_kind     (o_out_kind),
        .o_payload_byte (o_payload_byte),
        .o_payload_len  (o_payload_len),
        .o_error_code   (o_error_code),
        .o_ack_kind     (o_ack_kind),
        .o_ack_seq      (o_ack_seq)
    );

    // Parser copy
    t_cfg       rx_cfg = '{RST_FLAG, RST_ADDR, RST_CTRL0, RST_CTRL1, RST_ESCAPE, RST_MASK};
    logic [2:0] p_state = ST_HUNT;
    logic       seq_want = 1'b0;
    logic       esc_open = 1'b0;
    logic [7:0] held_byte = '0;
    logic       held_ok = 1'b0;
    logic [7:0] xor_acc = '0;
    int         paid_cnt = 0;

    t_result     exp_results [$];
    int unsigned cycles = 0;
    int unsigned n_mismatch = 0;
    int unsigned n_bytes = 0;
    int unsigned n_payload = 0;
    int unsigned n_report = 0;
    int unsigned n_err [4] = '{0, 0, 0, 0};
    int unsigned n_settings = 1;
    int unsigned n_holds = 0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     exp_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic frame_clear();
        esc_open  = 1'b0;
        held_byte = '0;
        held_ok   = 1'b0;
        xor_acc   = '0;
        paid_cnt  = 0;
    endtask

    task automatic frame_predict(input logic [7:0] c, output bit got, output t_result r);
        logic [7:0] ctl;
        logic [7:0] d;
        logic [7:0] rel;
        logic [1:0] err;
        got = 1'b0;
        r   = '0;
        ctl = seq_want ? rx_cfg.ctrl_seq_one : rx_cfg.ctrl_seq_zero;
        case (p_state)
            ST_FLAG: begin
                if (c == rx_cfg.flag_byte) p_state = ST_FLAG;
                else if (c == rx_cfg.address_byte) p_state = ST_ADDR;
                else p_state = ST_HUNT;
            end
            ST_ADDR: begin
                if (c == rx_cfg.flag_byte) p_state = ST_FLAG;
                else if (c == ctl) p_state = ST_CTRL;
                else p_state = ST_HUNT;
            end
            ST_CTRL: begin
                if (c == rx_cfg.flag_byte) begin
                    p_state = ST_FLAG;
                end else if (c == (rx_cfg.address_byte ^ ctl)) begin
                    p_state = ST_DATA;
                    frame_clear();
                end else begin
                    p_state = ST_HUNT;
                end
            end
            ST_DATA: begin
                if (c == rx_cfg.flag_byte) begin
                    if (esc_open || !held_ok) err = ERR_MALFORM;
                    else if (paid_cnt > MAX_PAYLOAD) err = ERR_LONG;
                    else if (xor_acc != held_byte) err = ERR_PARITY;
                    else err = ERR_OK;
                    if (err == ERR_OK) seq_want = ~seq_want;
                    got = 1'b1;
                    r.out_kind    = KIND_REPORT;
                    r.payload_len = (paid_cnt > MAX_PAYLOAD) ? CNT_W'(MAX_PAYLOAD)
                                                             : CNT_W'(paid_cnt);
                    r.error_code  = err;
                    r.ack_kind    = (err == ERR_OK) ? ACK_RR : ACK_REJ;
                    r.ack_seq     = seq_want;
                    p_state = ST_HUNT;
                    frame_clear();
                end else if (!esc_open && c == rx_cfg.escape_byte) begin
                    esc_open = 1'b1;
                end else begin
                    d = esc_open ? (c ^ rx_cfg.unstuff_mask) : c;
                    esc_open = 1'b0;
                    if (!held_ok) begin
                        held_byte = d;
                        held_ok   = 1'b1;
                    end else begin
                        // one byte held back so the trailing parity never goes out
                        rel = held_byte;
                        held_byte = d;
                        if (paid_cnt >= MAX_PAYLOAD) begin
                            paid_cnt = MAX_PAYLOAD + 1;
                        end else begin
                            paid_cnt++;
                            xor_acc ^= rel;
                            got = 1'b1;
                            r.out_kind     = KIND_PAYLOAD;
                            r.payload_byte = rel;
                        end
                    end
                end
            end
            default: begin
                p_state = (c == rx_cfg.flag_byte) ? ST_FLAG : ST_HUNT;
            end
        endcase
    endtask

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_idle_on || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic line_send(input logic [7:0] b, input bit typed_on = 1'b0,
                             input t_result typed = '0);
        int gap;
        bit got;
        t_result r;
        gap = tx_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        frame_predict(b, got, r);
        if (typed_on) exp_results.push_back(typed);
        else if (got) exp_results.push_back(r);
        n_bytes++;
    endtask

    task automatic stuffed_send(input logic [7:0] b);
        if (b == rx_cfg.flag_byte || b == rx_cfg.escape_byte || $urandom_range(0, 19) == 0)
        begin
            line_send(rx_cfg.escape_byte);
            line_send(b ^ rx_cfg.unstuff_mask);
        end else begin
            line_send(b);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return rx_cfg.flag_byte;
            1: return rx_cfg.escape_byte;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic frame_send(input int len, input t_flavor fl);
        logic [7:0] ctl;
        logic [7:0] par;
        logic [7:0] b;
        ctl = seq_want ? rx_cfg.ctrl_seq_one : rx_cfg.ctrl_seq_zero;
        if (fl == F_STALE_SEQ) ctl = seq_want ? rx_cfg.ctrl_seq_zero : rx_cfg.ctrl_seq_one;
        line_send(rx_cfg.flag_byte);
        if ($urandom_range(0, 3) == 0) line_send(rx_cfg.flag_byte);
        line_send(rx_cfg.address_byte);
        if (fl == F_TRUNC) begin
            line_send(8'($urandom));
            return;
        end
        line_send(ctl);
        if (fl == F_BAD_CHECK)
            line_send(rx_cfg.address_byte ^ ctl ^ (8'h01 << $urandom_range(0, 7)));
        else
            line_send(rx_cfg.address_byte ^ ctl);
        par = '0;
        if (fl != F_EMPTY) begin
            for (int k = 0; k < len; k++) begin
                b = pick_byte();
                par ^= b;
                stuffed_send(b);
            end
            if (fl == F_BAD_PARITY) par ^= 8'h01 << $urandom_range(0, 7);
            stuffed_send(par);
        end
        if (fl == F_DANGLE) line_send(rx_cfg.escape_byte);
        line_send(rx_cfg.flag_byte);
    endtask

    task automatic random_frame();
        int r;
        int len;
        t_flavor fl;
        tx_idle_on = ($urandom_range(0, 4) != 0);
        rx_idle_on = ($urandom_range(0, 4) != 0);
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 8);
        else if (r < 95) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 120);
        r = $urandom_range(0, 99);
        if (r < 62) fl = F_GOOD;
        else if (r < 70) fl = F_BAD_PARITY;
        else if (r < 76) fl = F_DANGLE;
        else if (r < 82) fl = F_EMPTY;
        else if (r < 88) fl = F_STALE_SEQ;
        else if (r < 94) fl = F_BAD_CHECK;
        else fl = F_TRUNC;
        frame_send(len, fl);
        repeat ($urandom_range(0, 2)) line_send(8'($urandom));
    endtask

    // Drop valid, let every expected beat come out, then give the pipe time to empty
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_FLAG:   rx_cfg.flag_byte     = val;
            REG_ADDR:   rx_cfg.address_byte  = val;
            REG_CTRL0:  rx_cfg.ctrl_seq_zero = val;
            REG_CTRL1:  rx_cfg.ctrl_seq_one  = val;
            REG_ESCAPE: rx_cfg.escape_byte   = val;
            REG_MASK:   rx_cfg.unstuff_mask  = val;
            default: ;
        endcase
    endtask

    task automatic cfg_load(input t_cfg c);
        cfg_write(REG_FLAG, c.flag_byte);
        cfg_write(REG_ADDR, c.address_byte);
        cfg_write(REG_CTRL0, c.ctrl_seq_zero);
        cfg_write(REG_CTRL1, c.ctrl_seq_one);
        cfg_write(REG_ESCAPE, c.escape_byte);
        cfg_write(REG_MASK, c.unstuff_mask);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic t_cfg phase_cfg(input int ph);
        t_cfg c;
        case (ph)
            0: c = '{RST_FLAG, RST_ADDR, RST_CTRL0, RST_CTRL1, RST_ESCAPE, RST_MASK};
            1: c = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'hFF};
            2: c = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00, 8'h00};
            default: begin
                // keep the flag clear of the header bytes so frames can open
                do begin
                    c.flag_byte     = 8'($urandom);
                    c.address_byte  = 8'($urandom);
                    c.ctrl_seq_zero = 8'($urandom);
                    c.ctrl_seq_one  = 8'($urandom);
                    c.escape_byte   = 8'($urandom);
                    c.unstuff_mask  = 8'($urandom);
                end while (c.flag_byte == c.address_byte || c.flag_byte == c.escape_byte ||
                           c.flag_byte == c.ctrl_seq_zero || c.flag_byte == c.ctrl_seq_one ||
                           c.ctrl_seq_zero == c.ctrl_seq_one ||
                           c.flag_byte == (c.address_byte ^ c.ctrl_seq_zero) ||
                           c.flag_byte == (c.address_byte ^ c.ctrl_seq_one));
            end
        endcase
        return c;
    endfunction

    // Output side: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            n_holds++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!rx_idle_on || $urandom_range(0, 99) < 70) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 30);
            i_out_ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_out_kind, o_payload_byte, o_payload_len, o_error_code, o_ack_kind,
                     o_ack_seq};
            if (seen.out_kind == KIND_REPORT) begin
                n_report++;
                n_err[seen.error_code]++;
            end else begin
                n_payload++;
            end
            if (exp_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR cycle %0d: unexpected beat kind=%0d byte=%02h err=%0d",
                             cycles, seen.out_kind, seen.payload_byte, seen.error_code);
            end else begin
                want = exp_results.pop_front();
                if (seen.out_kind !== want.out_kind || seen.payload_byte !== want.payload_byte ||
                    seen.payload_len !== want.payload_len ||
                    seen.error_code !== want.error_code || seen.ack_kind !== want.ack_kind ||
                    seen.ack_seq !== want.ack_seq) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"ERROR cycle %0d: got kind=%0d byte=%02h len=%0d err=%0d ",
                                  "ack=%0d seq=%0d, want kind=%0d byte=%02h len=%0d err=%0d ",
                                  "ack=%0d seq=%0d"}, cycles,
                                 seen.out_kind, seen.payload_byte, seen.payload_len,
                                 seen.error_code, seen.ack_kind, seen.ack_seq,
                                 want.out_kind, want.payload_byte, want.payload_len,
                                 want.error_code, want.ack_kind, want.ack_seq);
                end
            end
        end
    end

    initial begin
        int start;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) line_send(DIRECTED[k].line, DIRECTED[k].typed_on,
                                        DIRECTED[k].typed);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                quiesce();
                cfg_load(phase_cfg(ph));
            end
            start = n_bytes;
            if (ph == 1 || ph == 4) begin
                // output held off while a back-to-back frame keeps arriving
                @(posedge i_clk);
                hold_req   = 1'b1;
                tx_idle_on = 1'b0;
                frame_send(80, F_GOOD);
            end
            while (n_bytes - start < PHASE_BYTES) random_frame();
        end

        // largest legal frame, then one five bytes past the limit
        quiesce();
        cfg_load(phase_cfg(0));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        frame_send(MAX_PAYLOAD, F_GOOD);
        frame_send(MAX_PAYLOAD + 5, F_GOOD);
        quiesce();

        $display("Sent %0d line bytes over %0d register settings, %0d long output hold-offs.",
                 n_bytes, n_settings, n_holds);
        $display("Checked %0d payload beats, %0d reports (ok %0d, parity %0d, long %0d, bad %0d).",
                 n_payload, n_report, n_err[ERR_OK], n_err[ERR_PARITY], n_err[ERR_LONG],
                 n_err[ERR_MALFORM]);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
